// ===== hdl/cat_pkg.sv =====
// Shared types and constants for the countdown alarm timer.
package cat_pkg;

    localparam int TIME_W = 32;
    localparam int REM_W  = 22;
    localparam int TOT_W  = 12;

    typedef enum logic [1:0] {
        MODE_SET   = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_ALARM = 2'd2
    } mode_t;

    localparam logic [2:0] KIND_TAP      = 3'd0;
    localparam logic [2:0] KIND_TICK     = 3'd1;
    localparam logic [2:0] KIND_STEP_MIN = 3'd2;
    localparam logic [2:0] KIND_STEP_SEC = 3'd3;
    localparam logic [2:0] KIND_LEAVE    = 3'd4;

    localparam logic CFG_CHIME_ROUNDS = 1'b0;
    localparam logic CFG_PULSE_PERIOD = 1'b1;

    localparam logic [3:0]  CHIME_ROUNDS_RST = 4'd5;
    localparam logic [15:0] PULSE_PERIOD_RST = 16'd400;

    localparam int NOTES_PER_ROUND = 3;
    localparam int NOTE_MS         = 150;
    localparam int GAP_MS          = 50;
    localparam int ROUND_PAUSE_MS  = 300;
    localparam int MS_PER_SEC      = 1000;
    localparam int SECS_PER_MIN    = 60;
    localparam int MAX_SETTING     = 59;

    localparam logic [TIME_W-1:0] NOTE_STEP_MS = TIME_W'(NOTE_MS + GAP_MS);
    localparam logic [TIME_W-1:0] ROUND_STEP_MS =
        TIME_W'(NOTES_PER_ROUND * (NOTE_MS + GAP_MS) + ROUND_PAUSE_MS);

    // ceil(2^32/1000) and ceil(2^18/60); exact over the ranges used here
    localparam logic [22:0] RECIP_1000 = 23'd4294968;
    localparam logic [12:0] RECIP_60   = 13'd4370;

    typedef struct packed {
        mode_t            mode;
        logic [5:0]       set_mins;
        logic [5:0]       set_secs;
        logic [REM_W-1:0] remaining;
        logic             play;
        logic [1:0]       note;
        logic             highlight;
    } res_t;

endpackage

// ===== hdl/cat_ctrl.sv =====
// Timer state update: mode machine, countdown, pulse and chime schedule.
module cat_ctrl import cat_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        in_kind,
    input  logic [TIME_W-1:0] in_now,
    input  logic [6:0]        in_step,
    input  logic [3:0]        chime_rounds,
    input  logic [15:0]       pulse_period,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res
);

    mode_t              mode_reg, mode_next;
    logic [5:0]         set_min_reg, set_min_next;
    logic [5:0]         set_sec_reg, set_sec_next;
    logic [REM_W-1:0]   remaining_reg, remaining_next;
    logic [TIME_W-1:0]  last_tick_reg, last_tick_next;
    logic [3:0]         round_reg, round_next;
    logic [1:0]         note_reg, note_next;
    logic [TIME_W-1:0]  chime_time_reg, chime_time_next;
    logic               phase_reg, phase_next;
    logic [TIME_W-1:0]  pulse_time_reg, pulse_time_next;
    logic               valid_reg;
    res_t               res_reg, res_next;

    logic               fire;
    logic [TIME_W-1:0]  delta;
    logic               expired;
    logic               pulse_due;
    logic               chime_due;
    logic [1:0]         note_inc;
    logic               round_end;
    logic [3:0]         round_after;
    logic               alarm_done;
    logic               set_nonzero;
    logic [REM_W-1:0]   set_ms;
    logic               play;
    logic [1:0]         play_idx;

    function automatic logic [5:0] clamp_add(input logic [5:0] cur, input logic [6:0] d);
        logic signed [7:0] v;
        v = $signed({2'b00, cur}) + $signed({d[6], d});
        if (v < 0) begin
            return 6'd0;
        end else if (v > 8'sd59) begin
            return 6'(MAX_SETTING);
        end
        return v[5:0];
    endfunction

    assign in_ready    = !valid_reg || res_ready;
    assign fire        = in_valid && in_ready;
    assign delta       = in_now - last_tick_reg;
    assign expired     = delta >= {{(TIME_W-REM_W){1'b0}}, remaining_reg};
    assign pulse_due   = (in_now - pulse_time_reg) >= {16'd0, pulse_period};
    assign chime_due   = (round_reg < chime_rounds) && (in_now >= chime_time_reg);
    assign note_inc    = note_reg + 2'd1;
    assign round_end   = note_inc >= 2'(NOTES_PER_ROUND);
    assign round_after = (chime_due && round_end) ? round_reg + 4'd1 : round_reg;
    assign alarm_done  = round_after >= chime_rounds;
    assign set_nonzero = (set_min_reg != 6'd0) || (set_sec_reg != 6'd0);
    assign set_ms      = REM_W'(set_min_reg) * REM_W'(SECS_PER_MIN * MS_PER_SEC)
                       + REM_W'(set_sec_reg) * REM_W'(MS_PER_SEC);

    // next mode
    always_comb begin
        mode_next = mode_reg;
        if (fire) begin
            case (in_kind)
                KIND_TAP: begin
                    if (mode_reg == MODE_ALARM || mode_reg == MODE_RUN) begin
                        mode_next = MODE_SET;
                    end else if (set_nonzero) begin
                        mode_next = MODE_RUN;
                    end
                end
                KIND_TICK: begin
                    if (mode_reg == MODE_RUN && expired) begin
                        mode_next = MODE_ALARM;
                    end else if (mode_reg == MODE_ALARM && alarm_done) begin
                        mode_next = MODE_SET;
                    end
                end
                KIND_LEAVE: begin
                    if (mode_reg == MODE_ALARM) begin
                        mode_next = MODE_SET;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath state
    always_comb begin
        set_min_next    = set_min_reg;
        set_sec_next    = set_sec_reg;
        remaining_next  = remaining_reg;
        last_tick_next  = last_tick_reg;
        round_next      = round_reg;
        note_next       = note_reg;
        chime_time_next = chime_time_reg;
        phase_next      = phase_reg;
        pulse_time_next = pulse_time_reg;
        play            = 1'b0;
        play_idx        = 2'd0;
        if (fire) begin
            case (in_kind)
                KIND_TAP: begin
                    if (mode_reg == MODE_ALARM) begin
                        note_next = 2'd0;
                    end else if (mode_reg == MODE_SET && set_nonzero) begin
                        remaining_next = set_ms;
                        last_tick_next = in_now;
                    end
                end
                KIND_TICK: begin
                    if (mode_reg == MODE_RUN) begin
                        last_tick_next = in_now;
                        if (expired) begin
                            remaining_next  = '0;
                            round_next      = 4'd0;
                            note_next       = 2'd0;
                            chime_time_next = in_now;
                            phase_next      = 1'b0;
                            pulse_time_next = in_now;
                        end else begin
                            // delta is below remaining here, so it fits
                            remaining_next = remaining_reg - delta[REM_W-1:0];
                        end
                    end else if (mode_reg == MODE_ALARM) begin
                        if (pulse_due) begin
                            phase_next      = !phase_reg;
                            pulse_time_next = in_now;
                        end
                        if (chime_due) begin
                            play     = 1'b1;
                            play_idx = note_reg;
                            if (round_end) begin
                                note_next       = 2'd0;
                                round_next      = round_after;
                                chime_time_next = in_now + ROUND_STEP_MS;
                            end else begin
                                note_next       = note_inc;
                                chime_time_next = in_now + NOTE_STEP_MS;
                            end
                        end
                        if (alarm_done) begin
                            note_next = 2'd0;
                        end
                    end
                end
                KIND_STEP_MIN: begin
                    if (mode_reg == MODE_SET) begin
                        set_min_next = clamp_add(set_min_reg, in_step);
                    end
                end
                KIND_STEP_SEC: begin
                    if (mode_reg == MODE_SET) begin
                        set_sec_next = clamp_add(set_sec_reg, in_step);
                    end
                end
                KIND_LEAVE: begin
                    if (mode_reg == MODE_ALARM) begin
                        note_next = 2'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    // result word for this item
    always_comb begin
        res_next.mode      = mode_next;
        res_next.set_mins  = set_min_next;
        res_next.set_secs  = set_sec_next;
        res_next.remaining = remaining_next;
        res_next.play      = play;
        res_next.note      = play_idx;
        res_next.highlight = (mode_next == MODE_ALARM) && phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_SET;
            set_min_reg    <= '0;
            set_sec_reg    <= '0;
            remaining_reg  <= '0;
            last_tick_reg  <= '0;
            round_reg      <= '0;
            note_reg       <= '0;
            chime_time_reg <= '0;
            phase_reg      <= 1'b0;
            pulse_time_reg <= '0;
            valid_reg      <= 1'b0;
        end else begin
            mode_reg       <= mode_next;
            set_min_reg    <= set_min_next;
            set_sec_reg    <= set_sec_next;
            remaining_reg  <= remaining_next;
            last_tick_reg  <= last_tick_next;
            round_reg      <= round_next;
            note_reg       <= note_next;
            chime_time_reg <= chime_time_next;
            phase_reg      <= phase_next;
            pulse_time_reg <= pulse_time_next;
            if (in_ready) begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

    a_tap_stops_run: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_kind == KIND_TAP && mode_reg == MODE_RUN |=> mode_reg == MODE_SET)
        else $error("tap while running did not stop the count");

    a_note_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != MODE_ALARM |-> note_reg == 2'd0)
        else $error("note pointer not cleared outside alarm");

    a_note_range: assert property (@(posedge aclk) disable iff (!aresetn)
        note_reg < 2'(NOTES_PER_ROUND))
        else $error("note pointer beyond round");

    a_run_counts_down: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_kind == KIND_TICK && mode_reg == MODE_RUN && !expired
        |=> remaining_reg <= $past(remaining_reg) && mode_reg == MODE_RUN)
        else $error("countdown grew on a tick");

endmodule

// ===== hdl/cat_disp.sv =====
// Display pipeline: splits the remaining milliseconds into minutes and seconds.
module cat_disp import cat_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  res_t       in_res,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] out_mode,
    output logic [5:0] out_mins,
    output logic [5:0] out_secs,
    output logic       out_play,
    output logic [1:0] out_note,
    output logic       out_highlight
);

    logic             vb_reg, vc_reg, vo_reg;
    logic             ready_c, ready_o;
    res_t             db_reg, dc_reg;
    logic [TOT_W-1:0] totb_reg, totc_reg;
    logic [5:0]       minc_reg;
    logic [44:0]      prod_sec;
    logic [24:0]      prod_min;
    logic [TOT_W-1:0] secs_full;
    logic [5:0]       mins_sel, secs_sel;
    logic [1:0]       mode_o_reg;
    logic [5:0]       mins_o_reg, secs_o_reg;
    logic             play_o_reg, hl_o_reg;
    logic [1:0]       note_o_reg;

    assign ready_o  = !vo_reg || out_ready;
    assign ready_c  = !vc_reg || ready_o;
    assign in_ready = !vb_reg || ready_c;

    // whole seconds, then minutes, by reciprocal multiply
    assign prod_sec  = 45'(in_res.remaining) * 45'(RECIP_1000);
    assign prod_min  = 25'(totb_reg) * 25'(RECIP_60);
    assign secs_full = totc_reg - ((TOT_W'(minc_reg) << 6) - (TOT_W'(minc_reg) << 2));
    assign mins_sel  = (dc_reg.mode == MODE_SET) ? dc_reg.set_mins : minc_reg;
    assign secs_sel  = (dc_reg.mode == MODE_SET) ? dc_reg.set_secs : secs_full[5:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                vb_reg <= in_valid;
            end
            if (ready_c) begin
                vc_reg <= vb_reg;
            end
            if (ready_o) begin
                vo_reg <= vc_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            db_reg   <= in_res;
            totb_reg <= prod_sec[32 +: TOT_W];
        end
        if (ready_c && vb_reg) begin
            dc_reg   <= db_reg;
            totc_reg <= totb_reg;
            minc_reg <= prod_min[23:18];
        end
        if (ready_o && vc_reg) begin
            mode_o_reg <= dc_reg.mode;
            mins_o_reg <= mins_sel;
            secs_o_reg <= secs_sel;
            play_o_reg <= dc_reg.play;
            note_o_reg <= dc_reg.note;
            hl_o_reg   <= dc_reg.highlight;
        end
    end

    assign out_valid     = vo_reg;
    assign out_mode      = mode_o_reg;
    assign out_mins      = mins_o_reg;
    assign out_secs      = secs_o_reg;
    assign out_play      = play_o_reg;
    assign out_note      = note_o_reg;
    assign out_highlight = hl_o_reg;

    a_secs_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vc_reg && dc_reg.mode != MODE_SET |-> secs_full < TOT_W'(SECS_PER_MIN))
        else $error("seconds split out of range");

    a_mins_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vo_reg |-> mins_o_reg <= 6'(MAX_SETTING))
        else $error("minutes out of range");

    a_no_note_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        vo_reg && !play_o_reg |-> note_o_reg == 2'd0)
        else $error("note index set without a note");

endmodule

// ===== hdl/countdown_alarm_timer.sv =====
// Top level of the countdown alarm timer: ports, settings registers, word packing.
//
// Input words arrive on the s_ channel: s_tuser carries the event kind (tap, tick,
// step minutes, step seconds, leave), s_tdata the millisecond time and step amount.
// Every accepted word gives exactly one result word on the m_ channel: the mode,
// the shown minutes and seconds, a chime note trigger and the alarm highlight,
// all as they stand after that event.
// Settings go in through the cfg_ channel (index 0 chime rounds, 1 pulse period);
// cfg_ready is always high and a write takes effect on the next word.
// Pipeline: the state update registers the result word; the two reciprocal multiplies
// that split the remaining milliseconds into minutes and seconds take one stage each,
// and the output register comes last.
// Throughput: one word per cycle while the m_ side keeps up. A stalled m_ side fills the
// four stages one by one; s_tready drops only when all of them hold words.
// Reset (aresetn low at a clock edge) returns to set mode with 0:00, clears the
// pipeline, and loads 5 chime rounds and a 400 ms pulse period.
module countdown_alarm_timer import cat_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // now_ms[31:0], step_amount[38:32], zero [39]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // mode[1:0], show_mins[7:2], show_secs[13:8],
                                   // play_note[14], note_index[16:15], highlight[17],
                                   // zero [23:18]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic [3:0]  chime_rounds_reg;
    logic [15:0] pulse_period_reg;
    logic        res_valid, res_ready;
    res_t        res;
    logic [1:0]  out_mode;
    logic [5:0]  out_mins, out_secs;
    logic        out_play, out_highlight;
    logic [1:0]  out_note;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chime_rounds_reg <= CHIME_ROUNDS_RST;
            pulse_period_reg <= PULSE_PERIOD_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CHIME_ROUNDS: chime_rounds_reg <= cfg_data[3:0];
                CFG_PULSE_PERIOD: pulse_period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    cat_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_kind      (s_tuser),
        .in_now       (s_tdata[31:0]),
        .in_step      (s_tdata[38:32]),
        .chime_rounds (chime_rounds_reg),
        .pulse_period (pulse_period_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    cat_disp u_disp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (res_valid),
        .in_ready      (res_ready),
        .in_res        (res),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_mode      (out_mode),
        .out_mins      (out_mins),
        .out_secs      (out_secs),
        .out_play      (out_play),
        .out_note      (out_note),
        .out_highlight (out_highlight)
    );

    assign m_tdata = {6'd0, out_highlight, out_note, out_play, out_secs, out_mins, out_mode};

endmodule

// ===== verif/countdown_alarm_timer_checker.sv =====
// Checker for the countdown alarm timer: predicts every result word and compares it.
`timescale 1ns / 100ps

module countdown_alarm_timer_checker import cat_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // now_ms[31:0], step_amount[38:32], zero [39]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // mode[1:0], show_mins[7:2], show_secs[13:8],
                                   // play_note[14], note_index[16:15], highlight[17],
                                   // zero [23:18]
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending
);

    typedef struct {
        mode_t      mode;
        logic [5:0] mins;
        logic [5:0] secs;
        logic       play;
        logic [1:0] note;
        logic       highlight;
    } timer_view_t;

    timer_view_t pending_views[$];
    int          err_count = 0;
    int          backlog   = 0;

    // settings as the block holds them
    logic [3:0]  chime_rounds = CHIME_ROUNDS_RST;
    logic [15:0] pulse_period = PULSE_PERIOD_RST;

    // timer state
    mode_t            tm_mode       = MODE_SET;
    logic [5:0]       tm_set_min    = '0;
    logic [5:0]       tm_set_sec    = '0;
    logic [REM_W-1:0] tm_remaining  = '0;
    logic [31:0]      tm_last_tick  = '0;
    logic [3:0]       tm_rounds     = '0;
    logic [1:0]       tm_next_note  = '0;
    logic [31:0]      tm_next_chime = '0;
    logic             tm_phase      = 1'b0;
    logic [31:0]      tm_last_pulse = '0;

    assign errors  = err_count;
    assign pending = backlog;

    function automatic logic [5:0] clamp_setting(input logic [5:0] cur,
                                                 input logic signed [6:0] delta);
        int v;
        v = int'(cur) + int'(delta);
        if (v < 0) v = 0;
        if (v > MAX_SETTING) v = MAX_SETTING;
        return 6'(v);
    endfunction

    function automatic void drop_alarm();
        tm_mode      = MODE_SET;
        tm_next_note = '0;
    endfunction

    function automatic timer_view_t advance_timer(input logic [2:0] kind,
                                                  input logic [31:0] now,
                                                  input logic [6:0] step);
        timer_view_t v;
        logic [31:0] delta;
        int unsigned secs_left;
        v.play = 1'b0;
        v.note = '0;
        case (kind)
            KIND_TAP: begin
                if (tm_mode == MODE_ALARM) begin
                    drop_alarm();
                end else if (tm_mode == MODE_SET) begin
                    if (tm_set_min != 0 || tm_set_sec != 0) begin
                        tm_remaining = REM_W'((int'(tm_set_min) * SECS_PER_MIN
                                               + int'(tm_set_sec)) * MS_PER_SEC);
                        tm_last_tick = now;
                        tm_mode      = MODE_RUN;
                    end
                end else begin
                    tm_mode = MODE_SET;
                end
            end
            KIND_TICK: begin
                if (tm_mode == MODE_RUN) begin
                    delta        = now - tm_last_tick;
                    tm_last_tick = now;
                    if (delta >= 32'(tm_remaining)) begin
                        // expiry: alarm starts, first note comes on a later tick
                        tm_remaining  = '0;
                        tm_mode       = MODE_ALARM;
                        tm_rounds     = '0;
                        tm_next_note  = '0;
                        tm_next_chime = now;
                        tm_phase      = 1'b0;
                        tm_last_pulse = now;
                    end else begin
                        tm_remaining = tm_remaining - REM_W'(delta);
                    end
                end else if (tm_mode == MODE_ALARM) begin
                    if (now - tm_last_pulse >= 32'(pulse_period)) begin
                        tm_phase      = ~tm_phase;
                        tm_last_pulse = now;
                    end
                    if (tm_rounds < chime_rounds && now >= tm_next_chime) begin
                        v.play = 1'b1;
                        v.note = tm_next_note;
                        if (int'(tm_next_note) == NOTES_PER_ROUND - 1) begin
                            tm_next_note  = '0;
                            tm_rounds     = tm_rounds + 4'd1;
                            tm_next_chime = now + ROUND_STEP_MS;
                        end else begin
                            tm_next_note  = tm_next_note + 2'd1;
                            tm_next_chime = now + NOTE_STEP_MS;
                        end
                    end
                    if (tm_rounds >= chime_rounds) drop_alarm();
                end
            end
            KIND_STEP_MIN: begin
                if (tm_mode == MODE_SET) tm_set_min = clamp_setting(tm_set_min, step);
            end
            KIND_STEP_SEC: begin
                if (tm_mode == MODE_SET) tm_set_sec = clamp_setting(tm_set_sec, step);
            end
            KIND_LEAVE: begin
                if (tm_mode == MODE_ALARM) drop_alarm();
            end
            default: ;
        endcase

        v.mode = tm_mode;
        if (tm_mode == MODE_SET) begin
            v.mins = tm_set_min;
            v.secs = tm_set_sec;
        end else begin
            secs_left = tm_remaining / MS_PER_SEC;
            v.mins    = 6'(secs_left / SECS_PER_MIN);
            v.secs    = 6'(secs_left % SECS_PER_MIN);
        end
        v.highlight = (tm_mode == MODE_ALARM) ? tm_phase : 1'b0;
        return v;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            err_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        timer_view_t want;
        if (!aresetn) begin
            chime_rounds  = CHIME_ROUNDS_RST;
            pulse_period  = PULSE_PERIOD_RST;
            tm_mode       = MODE_SET;
            tm_set_min    = '0;
            tm_set_sec    = '0;
            tm_remaining  = '0;
            tm_last_tick  = '0;
            tm_rounds     = '0;
            tm_next_note  = '0;
            tm_next_chime = '0;
            tm_phase      = 1'b0;
            tm_last_pulse = '0;
            pending_views.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_CHIME_ROUNDS) chime_rounds = cfg_data[3:0];
                else pulse_period = cfg_data;
            end
            if (m_tvalid && m_tready) begin
                if (pending_views.size() == 0) begin
                    err_count++;
                    $display("%0t: result word %h with nothing expected, got %h",
                             $time, m_tdata, m_tdata);
                end else begin
                    want = pending_views.pop_front();
                    check_field("mode", int'(want.mode), int'(m_tdata[1:0]));
                    check_field("show_mins", int'(want.mins), int'(m_tdata[7:2]));
                    check_field("show_secs", int'(want.secs), int'(m_tdata[13:8]));
                    check_field("play_note", int'(want.play), int'(m_tdata[14]));
                    check_field("note_index", int'(want.note), int'(m_tdata[16:15]));
                    check_field("highlight", int'(want.highlight), int'(m_tdata[17]));
                    check_field("pad", 0, int'(m_tdata[23:18]));
                end
            end
            if (s_tvalid && s_tready)
                pending_views.push_back(advance_timer(s_tuser, s_tdata[31:0],
                                                      s_tdata[38:32]));
        end
        backlog = pending_views.size();
    end

endmodule

// ===== verif/countdown_alarm_timer_tb.sv =====
// Testbench top for the countdown alarm timer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module countdown_alarm_timer_tb;
    import cat_pkg::*;

    localparam logic [2:0] KIND_UNUSED_5 = 3'd5;
    localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
    localparam logic [2:0] KIND_UNUSED_7 = 3'd7;

    localparam int PIPE_DEPTH  = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_WORDS = 190;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;   // now_ms[31:0], step_amount[38:32], zero [39]
    logic [2:0]  s_tuser   = '0;   // kind[2:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // mode[1:0], show_mins[7:2], show_secs[13:8],
                                   // play_note[14], note_index[16:15], highlight[17],
                                   // zero [23:18]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_CHIME_ROUNDS;
    logic [15:0] cfg_data  = '0;

    int          errors;
    int          pending;

    logic [31:0] clock_ms   = '0;
    logic [3:0]  cur_rounds = CHIME_ROUNDS_RST;
    bit          no_gaps    = 1'b0;
    bit          hold_rx    = 1'b0;
    int          words_sent = 0;
    int          idle_cycles = 0;

    always #2 aclk = ~aclk;

    countdown_alarm_timer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    countdown_alarm_timer_checker chk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .errors   (errors),
        .pending  (pending)
    );

    // watchdog: cycles without any handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // result side: random back-pressure, one long hold-off on request
    initial begin
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_rx = 1'b0;
            end else begin
                gap = no_gaps ? 0 : $urandom_range(0, 4);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_word(input logic [2:0] kind, input logic [31:0] now,
                             input logic [6:0] step);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, step, now};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic noise_word();
        send_word(3'($urandom_range(0, 7)), $urandom, 7'($urandom));
    endtask

    // let every expected word come back, then a few quiet cycles
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (PIPE_DEPTH + 2) @(posedge aclk);
    endtask

    task automatic program_timer(input logic [3:0] rounds, input logic [15:0] period);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_CHIME_ROUNDS;
        cfg_data  <= {12'($urandom), rounds};   // upper bits are don't-care
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= CFG_PULSE_PERIOD;
        cfg_data  <= period;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        cur_rounds = rounds;
    endtask

    task automatic directed_words();
        send_word(KIND_UNUSED_5, 32'hFFFF_FFFF, 7'h7F);
        send_word(KIND_UNUSED_6, 32'h0, 7'h00);
        send_word(KIND_UNUSED_7, 32'h5A5A_A5A5, 7'h2A);
        send_word(KIND_TICK, 32'hFFFF_FFFF, 7'h7F);     // tick while setting
        send_word(KIND_LEAVE, 32'h0, 7'h00);            // leave while setting
        send_word(KIND_TAP, 32'd500, 7'h00);            // nothing set yet
        send_word(KIND_STEP_MIN, 32'h0, 7'h3F);         // +63 clamps to 59
        send_word(KIND_STEP_MIN, 32'h0, 7'h40);         // -64 clamps to 0
        send_word(KIND_STEP_SEC, 32'h0, 7'h40);
        send_word(KIND_STEP_SEC, 32'h0, 7'h3F);
        send_word(KIND_STEP_SEC, 32'h0, 7'h46);         // -58 leaves 0:01
        send_word(KIND_TAP, 32'd1000, 7'h00);
        send_word(KIND_STEP_MIN, 32'h0, 7'h05);         // ignored while running
        send_word(KIND_TICK, 32'd1500, 7'h00);
        send_word(KIND_TAP, 32'd1600, 7'h00);           // stop
        send_word(KIND_TAP, 32'd2000, 7'h00);           // restart from set time
        send_word(KIND_LEAVE, 32'd2100, 7'h00);         // no effect while running
        send_word(KIND_TICK, 32'd3000, 7'h00);          // expiry, no note yet
        send_word(KIND_TICK, 32'd3000, 7'h00);
        send_word(KIND_TICK, 32'd3200, 7'h00);
        send_word(KIND_TICK, 32'd3400, 7'h00);
        send_word(KIND_TAP, 32'd3450, 7'h00);           // cancel the alarm
        send_word(KIND_STEP_SEC, 32'h0, 7'h00);
    endtask

    // load a short time, start it, tick it down to expiry, then ride the alarm
    task automatic run_session();
        int unsigned mins, secs, total_ms, span, acc, d, alarm_ticks;
        if ($urandom_range(0, 7) == 0) clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 4000));
        send_word(KIND_LEAVE, clock_ms, 7'($urandom));
        mins = ($urandom_range(0, 5) == 0) ? 1 : 0;
        secs = $urandom_range(1, 20);
        send_word(KIND_STEP_MIN, $urandom, 7'h40);
        send_word(KIND_STEP_SEC, $urandom, 7'h40);
        if (mins != 0) send_word(KIND_STEP_MIN, $urandom, 7'd1);
        send_word(KIND_STEP_SEC, $urandom, 7'(secs));
        total_ms = (mins * 60 + secs) * 1000;
        send_word(KIND_TAP, clock_ms, 7'($urandom));
        span = total_ms / $urandom_range(2, 10);
        acc  = 0;
        while (acc < total_ms) begin
            case ($urandom_range(0, 29))
                0: begin
                    // stop, then start over from the set time
                    send_word(KIND_TAP, clock_ms, 7'($urandom));
                    send_word(KIND_TAP, clock_ms, 7'($urandom));
                    acc = 0;
                end
                1: send_word(KIND_STEP_SEC, $urandom, 7'($urandom));
                2: begin
                    // time goes backwards: huge wrapped delta expires at once
                    clock_ms = clock_ms - 32'($urandom_range(1, 1000));
                    send_word(KIND_TICK, clock_ms, 7'($urandom));
                    acc = total_ms;
                end
                3: send_word(3'($urandom_range(5, 7)), $urandom, 7'($urandom));
                default: begin
                    d        = $urandom_range(0, span);
                    clock_ms = clock_ms + d;
                    acc      = acc + d;
                    send_word(KIND_TICK, clock_ms, 7'($urandom));
                end
            endcase
        end
        alarm_ticks = int'(cur_rounds) * 6 + $urandom_range(1, 6);
        repeat (alarm_ticks) begin
            case ($urandom_range(0, 39))
                0: send_word(KIND_STEP_MIN, $urandom, 7'($urandom));
                1: send_word(KIND_TAP, clock_ms, 7'($urandom));
                default: begin
                    clock_ms = clock_ms + $urandom_range(0, 450);
                    send_word(KIND_TICK, clock_ms, 7'($urandom));
                end
            endcase
        end
        if ($urandom_range(0, 1)) send_word(KIND_LEAVE, clock_ms, 7'($urandom));
    endtask

    task automatic random_phase(input int target);
        int first;
        first = words_sent;
        while (words_sent - first < target) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) noise_word();
            end else begin
                run_session();
            end
        end
        no_gaps = 1'b0;
    endtask

    // back-to-back words against a stalled result side
    task automatic squeeze_input();
        no_gaps = 1'b1;
        hold_rx = 1'b1;
        repeat (30) noise_word();
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_words();
        random_phase(PHASE_WORDS);
        settle();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: program_timer(4'd1, 16'd1);
                1: program_timer(4'd15, 16'hFFFF);
                2: program_timer(4'd0, 16'd0);
                3: program_timer(CHIME_ROUNDS_RST, PULSE_PERIOD_RST);
                4: program_timer(4'($urandom_range(1, 4)), 16'($urandom_range(1, 600)));
                default: program_timer(4'($urandom), 16'($urandom));
            endcase
            if (phase == 3) squeeze_input();
            random_phase(PHASE_WORDS);
            settle();
        end

        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/cat_pkg.sv
hdl/cat_ctrl.sv
hdl/cat_disp.sv
hdl/countdown_alarm_timer.sv
verif/countdown_alarm_timer_checker.sv
verif/countdown_alarm_timer_tb.sv
